// File: hw/rtl/s2i_pkg.sv
package s2i_pkg;

  localparam int unsigned MAX_CHARS = 4096;
  localparam int POS_W = $clog2(MAX_CHARS + 1);
  localparam int BASE_W = 6;
  localparam int CHAR_W = 8;
  localparam int VAL_W = 64;

  localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CH_CR = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_PLUS = 8'd43;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CH_ZERO = 8'd48;
  localparam logic [CHAR_W-1:0] CH_NINE = 8'd57;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'd65;
  localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'd88;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'd90;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'd97;
  localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'd120;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'd122;

  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] BASE_ONE = 6'd1;
  localparam logic [BASE_W-1:0] BASE_OCT = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;

  typedef struct packed {
    logic is_space;
    logic is_plus;
    logic is_minus;
    logic is_zero;
    logic is_x;
    logic is_digit;
    logic [BASE_W-1:0] digit;
    logic last;
  } char_class_t;

endpackage

// File: hw/rtl/s2i_front.sv
module s2i_front (
  input  logic                       in_valid,
  input  logic [s2i_pkg::CHAR_W-1:0] char_code,
  input  logic                       last_char,
  input  logic                       q_full,
  output logic                       in_stall,
  output logic                       q_push,
  output s2i_pkg::char_class_t       q_item
);
  import s2i_pkg::*;

  logic [CHAR_W-1:0] off;

  always_comb begin
    q_item = '0;
    off = '0;
    q_item.last = last_char;
    q_item.is_space = (char_code == CH_SPACE) || (char_code >= CH_TAB && char_code <= CH_CR);
    q_item.is_plus = (char_code == CH_PLUS);
    q_item.is_minus = (char_code == CH_MINUS);
    q_item.is_zero = (char_code == CH_ZERO);
    q_item.is_x = (char_code == CH_LOWER_X) || (char_code == CH_UPPER_X);
    if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
      q_item.is_digit = 1'b1;
      off = char_code - CH_ZERO;
    end else if (char_code >= CH_LOWER_A && char_code <= CH_LOWER_Z) begin
      q_item.is_digit = 1'b1;
      off = char_code - CH_LOWER_A + CHAR_W'(BASE_DEC);
    end else if (char_code >= CH_UPPER_A && char_code <= CH_UPPER_Z) begin
      q_item.is_digit = 1'b1;
      off = char_code - CH_UPPER_A + CHAR_W'(BASE_DEC);
    end
    q_item.digit = off[BASE_W-1:0];
  end

  assign in_stall = q_full;
  assign q_push = in_valid && !q_full;

endmodule

// File: hw/rtl/s2i_queue.sv
module s2i_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  s2i_pkg::char_class_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 pop_valid,
  output s2i_pkg::char_class_t pop_item
);
  import s2i_pkg::*;

  char_class_t entries [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign full = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_item = entries[rd_ptr];

endmodule

// File: hw/rtl/s2i_back.sv
module s2i_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [s2i_pkg::BASE_W-1:0]        cfg_data,
  input  logic                              q_valid,
  input  s2i_pkg::char_class_t              q_item,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [s2i_pkg::VAL_W-1:0]  value,
  output logic                              overflowed,
  output logic [s2i_pkg::POS_W-1:0]         chars_consumed
);
  import s2i_pkg::*;

  localparam logic [2:0] PH_SPACE = 3'd0;
  localparam logic [2:0] PH_SIGNED = 3'd1;
  localparam logic [2:0] PH_ZERO = 3'd2;
  localparam logic [2:0] PH_ZEROX = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;

  localparam int PROD_W = VAL_W + BASE_W + 1;

  logic [BASE_W-1:0] number_base;
  logic [2:0] phase, phase_next;
  logic neg, neg_next;
  logic [VAL_W-1:0] acc, acc_next;
  logic ovf, ovf_next;
  logic [BASE_W-1:0] active_base, active_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [POS_W-1:0] end_offset, end_next;

  logic first_char;
  logic attempt;
  logic digit_ok;
  logic [BASE_W-1:0] fc_base;
  logic [BASE_W-1:0] tb;
  logic [PROD_W-1:0] sum;
  logic [PROD_W-1:0] limit;
  logic [VAL_W-1:0] result;

  always_comb begin
    phase_next = phase;
    neg_next = neg;
    acc_next = acc;
    ovf_next = ovf;
    active_next = active_base;
    end_next = end_offset;
    pos_next = (pos == POS_W'(MAX_CHARS)) ? pos : pos + POS_W'(1);
    first_char = 1'b0;
    attempt = 1'b0;
    tb = active_base;
    fc_base = (phase == PH_SPACE) ? number_base : active_base;

    unique case (phase)
      PH_SPACE: begin
        if (!q_item.is_space) begin
          active_next = number_base;
          if (number_base == BASE_ONE || number_base > BASE_MAX) begin
            phase_next = PH_DONE;
          end else if (q_item.is_plus || q_item.is_minus) begin
            neg_next = q_item.is_minus;
            phase_next = PH_SIGNED;
          end else begin
            first_char = 1'b1;
          end
        end
      end
      PH_SIGNED: begin
        first_char = 1'b1;
      end
      PH_ZERO: begin
        if (q_item.is_x) begin
          active_next = BASE_HEX;
          phase_next = PH_ZEROX;
        end else begin
          tb = (active_base == BASE_AUTO) ? BASE_OCT : active_base;
          active_next = tb;
          attempt = 1'b1;
        end
      end
      PH_ZEROX, PH_DIGITS: begin
        attempt = 1'b1;
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase

    if (first_char) begin
      if (q_item.is_zero && (fc_base == BASE_AUTO || fc_base == BASE_HEX)) begin
        end_next = pos_next;
        active_next = fc_base;
        phase_next = PH_ZERO;
      end else begin
        tb = (fc_base == BASE_AUTO) ? BASE_DEC : fc_base;
        active_next = tb;
        attempt = 1'b1;
      end
    end

    digit_ok = q_item.is_digit && (q_item.digit < tb);
    sum = ({{(PROD_W-VAL_W){1'b0}}, acc} * {{(PROD_W-BASE_W){1'b0}}, tb})
          + {{(PROD_W-BASE_W){1'b0}}, q_item.digit};
    limit = {{(PROD_W-VAL_W){1'b0}}, neg, {(VAL_W-1){!neg}}};

    if (attempt) begin
      if (digit_ok) begin
        if (!ovf) begin
          if (sum > limit) begin
            ovf_next = 1'b1;
          end else begin
            acc_next = sum[VAL_W-1:0];
          end
        end
        end_next = pos_next;
        phase_next = PH_DIGITS;
      end else begin
        phase_next = PH_DONE;
      end
    end

    if (ovf_next) begin
      result = {neg_next, {(VAL_W-1){!neg_next}}};
    end else if (neg_next) begin
      result = -acc_next;
    end else begin
      result = acc_next;
    end
  end

  assign q_pop = q_valid && (!q_item.last || !out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= BASE_AUTO;
      phase <= PH_SPACE;
      neg <= 1'b0;
      acc <= '0;
      ovf <= 1'b0;
      active_base <= BASE_AUTO;
      pos <= '0;
      end_offset <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        number_base <= cfg_data;
      end
      if (q_pop && q_item.last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        if (q_item.last) begin
          phase <= PH_SPACE;
          neg <= 1'b0;
          acc <= '0;
          ovf <= 1'b0;
          active_base <= BASE_AUTO;
          pos <= '0;
          end_offset <= '0;
        end else begin
          phase <= phase_next;
          neg <= neg_next;
          acc <= acc_next;
          ovf <= ovf_next;
          active_base <= active_next;
          pos <= pos_next;
          end_offset <= end_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.last) begin
      value <= $signed(result);
      overflowed <= ovf_next;
      chars_consumed <= end_next;
    end
  end

endmodule

// File: hw/rtl/string_to_integer_parser.sv
// Converts a string, fed one character per request, into a signed 64-bit integer in the
// manner of strtol, and gives one result on the request marked last. A character classifier
// feeds a two-entry queue that a conversion engine drains; the engine takes one character per
// cycle unless a held result stalls a last character, bounded by its multiply-by-base, add
// and limit compare on the 64-bit accumulator. A result is registered as its last character
// leaves the queue and is held until taken; later characters flow, up to the next last one.
// The base register is sampled at the first character of a string that is not whitespace.
module string_to_integer_parser (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [s2i_pkg::BASE_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [s2i_pkg::CHAR_W-1:0]        char_code,
  input  logic                              last_char,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [s2i_pkg::VAL_W-1:0]  value,
  output logic                              overflowed,
  output logic [s2i_pkg::POS_W-1:0]         chars_consumed
);
  import s2i_pkg::*;

  logic q_full;
  logic q_push;
  char_class_t push_item;
  logic q_pop;
  logic q_valid;
  char_class_t pop_item;

  s2i_front u_front (
    .in_valid  (in_valid),
    .char_code (char_code),
    .last_char (last_char),
    .q_full    (q_full),
    .in_stall  (in_stall),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  s2i_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (pop_item)
  );

  s2i_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .q_valid        (q_valid),
    .q_item         (pop_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .value          (value),
    .overflowed     (overflowed),
    .chars_consumed (chars_consumed)
  );

`ifndef SYNTH
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push)
    else $error("queue written while full");

  a_saturated_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflowed) |->
      (value == {1'b0, {(VAL_W-1){1'b1}}} || value == {1'b1, {(VAL_W-1){1'b0}}}))
    else $error("overflowed result is not saturated");

  a_overflow_has_digits: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflowed) |-> (chars_consumed != '0))
    else $error("overflow reported with nothing consumed");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (chars_consumed <= POS_W'(MAX_CHARS)))
    else $error("consumed count beyond limit");
`endif

endmodule
